/* hdl/pts_pkg.sv */
// Shared types and constants for the priority task scheduler.
// No dependencies; compiled first.
`default_nettype none
package pts_pkg;

   localparam int MAX_TASKS_DEF = 16;
   localparam logic [7:0] SLICE_RESET = 8'd10;

   typedef enum logic [1:0] {
      ST_FREE  = 2'd0,
      ST_READY = 2'd1,
      ST_BLOCK = 2'd2,
      ST_RUN   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      OP_TICK    = 3'd0,
      OP_YIELD   = 3'd1,
      OP_DELAY   = 3'd2,
      OP_CREATE  = 3'd3,
      OP_EXIT    = 3'd4,
      OP_RAISE   = 3'd5,
      OP_RESTORE = 3'd6,
      OP_START   = 3'd7
   } op_type;

   localparam logic [2:0] CSR_SLICE_TICKS = 3'd0;

   typedef struct packed {
      logic       latch;
      logic       tick_inc;
      logic       scan_start;
      logic       scan_step;
      logic       scan_expired;
      logic       wake;
      logic       disp_take;
      logic       disp_park;
      status_type park;
      logic       do_create;
      logic       do_raise;
      logic       do_restore;
      logic       exit_idle;
      logic       set_alarm;
      logic       slice_dec;
      logic       load_out;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   run;
      logic   delay_zero;
      logic   found;
      logic   scan_last;
      logic   prio_lt;
      logic   prio_eq;
      logic   slice_zero;
      logic   free_avail;
      logic   create_preempt;
      logic   out_free;
   } stat_type;

endpackage
`default_nettype wire

/* hdl/pts_if.sv */
// Valid/ready channel interfaces for scheduler request and response beats.
// Depends on nothing.
`default_nettype none
interface pts_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  opcode;
   logic [31:0] delay_ticks;
   logic [7:0]  priority_req;
   logic [3:0]  owner_id;
   modport source (output valid, opcode, delay_ticks, priority_req, owner_id, input ready);
   modport sink (input valid, opcode, delay_ticks, priority_req, owner_id, output ready);
endinterface

interface pts_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] running_id;
   logic       running_valid;
   logic       switched;
   logic [3:0] created_id;
   logic       create_ok;
   logic [4:0] woken_count;
   modport source (output valid, running_id, running_valid, switched, created_id,
                   create_ok, woken_count, input ready);
   modport sink (input valid, running_id, running_valid, switched, created_id,
                 create_ok, woken_count, output ready);
endinterface
`default_nettype wire

/* hdl/priority_task_scheduler_unit.sv */
// Top level of the priority task scheduler: controller, datapath and register block.
// Depends on pts_pkg, pts_if, pts_ctrl, pts_dpath, pts_csr.
//
//   port      dir    beat
//   req_bus   in     opcode, delay_ticks, priority_req, owner_id
//   rsp_bus   out    running_id, running_valid, switched, created_id, create_ok, woken_count
//   csr_*     apb    slice_ticks at offset 0
//
// One request at a time. Raise, restore, create without preemption and no-ops go from decode
// to finish; ops with a ready-list scan run scan and decide, plus take and park on dispatch.
// A tick runs one wakeup scan per woken task and a final empty one, then a ready-list scan if
// a task runs, plus take and park on a switch. The scan unit reads one task entry per cycle.
// Synchronous active-high reset, no clearing pass.
// A response stalled on rsp_bus holds the next result in the datapath until taken.
`default_nettype none
module priority_task_scheduler_unit #(
   parameter int MAX_TASKS = pts_pkg::MAX_TASKS_DEF
) (
   input  wire          clock,
   input  wire          reset,
   pts_req_if.sink      req_bus,
   pts_rsp_if.source    rsp_bus,
   input  wire          csr_psel,
   input  wire          csr_penable,
   input  wire          csr_pwrite,
   input  wire  [2:0]   csr_paddr,
   input  wire  [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   pts_pkg::cmd_type  cmd;
   pts_pkg::stat_type stat;
   logic [7:0]        slice_ticks;
   logic              req_ready;

   assign req_bus.ready = req_ready;

   pts_csr u_csr (
      .clock(clock), .reset(reset),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready), .slice_ticks(slice_ticks)
   );

   pts_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_bus.valid), .req_ready(req_ready),
      .stat(stat), .cmd(cmd)
   );

   pts_dpath #(.MAX_TASKS(MAX_TASKS)) u_dpath (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .in_opcode(req_bus.opcode), .in_delay_ticks(req_bus.delay_ticks),
      .in_priority_req(req_bus.priority_req), .in_owner_id(req_bus.owner_id),
      .slice_cfg(slice_ticks), .out_ready(rsp_bus.ready), .out_valid(rsp_bus.valid),
      .out_running_id(rsp_bus.running_id), .out_running_valid(rsp_bus.running_valid),
      .out_switched(rsp_bus.switched), .out_created_id(rsp_bus.created_id),
      .out_create_ok(rsp_bus.create_ok), .out_woken_count(rsp_bus.woken_count)
   );

endmodule
`default_nettype wire

/* hdl/pts_ctrl.sv */
// Scheduler controller: sequences scans, wakeups and dispatch for one request.
// Depends on pts_pkg.
`default_nettype none
module pts_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  pts_pkg::stat_type   stat,
   output pts_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_WSCAN, S_WEND, S_RSCAN, S_DECIDE, S_TAKE, S_PARK, S_FIN
   } state_type;

   state_type           state_ff, state_in;
   pts_pkg::status_type park_ff, park_in;

   always_comb begin
      cmd       = '0;
      cmd.park  = park_ff;
      state_in  = state_ff;
      park_in   = park_ff;
      req_ready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_FIN;
            park_in  = pts_pkg::ST_READY;
            unique case (stat.op)
               pts_pkg::OP_TICK: begin
                  cmd.tick_inc     = 1'b1;
                  cmd.scan_start   = 1'b1;
                  state_in         = S_WSCAN;
               end
               pts_pkg::OP_YIELD, pts_pkg::OP_DELAY, pts_pkg::OP_EXIT: begin
                  if (stat.run) begin
                     cmd.scan_start = 1'b1;
                     state_in       = S_RSCAN;
                  end
               end
               pts_pkg::OP_CREATE: begin
                  if (stat.free_avail) begin
                     cmd.do_create = 1'b1;
                     if (stat.run && stat.create_preempt) begin
                        cmd.scan_start = 1'b1;
                        state_in       = S_RSCAN;
                     end
                  end
               end
               pts_pkg::OP_RAISE:   cmd.do_raise = 1'b1;
               pts_pkg::OP_RESTORE: cmd.do_restore = stat.run;
               pts_pkg::OP_START: begin
                  if (!stat.run) begin
                     cmd.scan_start = 1'b1;
                     state_in       = S_RSCAN;
                  end
               end
               default: state_in = S_FIN;
            endcase
         end
         S_WSCAN: begin
            cmd.scan_step    = 1'b1;
            cmd.scan_expired = 1'b1;
            if (stat.scan_last) state_in = S_WEND;
         end
         S_WEND: begin
            if (stat.found) begin
               cmd.wake       = 1'b1;
               cmd.scan_start = 1'b1;
               state_in       = S_WSCAN;
            end else if (stat.run) begin
               cmd.scan_start = 1'b1;
               state_in       = S_RSCAN;
            end else begin
               state_in = S_FIN;
            end
         end
         S_RSCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = S_FIN;
            park_in  = pts_pkg::ST_READY;
            if (stat.found) begin
               unique case (stat.op)
                  pts_pkg::OP_TICK: begin
                     if (stat.prio_lt || (stat.prio_eq && stat.slice_zero)) begin
                        state_in = S_TAKE;
                     end else if (!stat.slice_zero) begin
                        cmd.slice_dec = 1'b1;
                     end
                  end
                  pts_pkg::OP_DELAY: begin
                     if (stat.delay_zero) begin
                        if (stat.prio_lt || stat.prio_eq) state_in = S_TAKE;
                     end else begin
                        cmd.set_alarm = 1'b1;
                        park_in       = pts_pkg::ST_BLOCK;
                        state_in      = S_TAKE;
                     end
                  end
                  pts_pkg::OP_YIELD, pts_pkg::OP_CREATE: begin
                     if (stat.prio_lt || stat.prio_eq) state_in = S_TAKE;
                  end
                  pts_pkg::OP_EXIT: begin
                     park_in  = pts_pkg::ST_FREE;
                     state_in = S_TAKE;
                  end
                  pts_pkg::OP_START: state_in = S_TAKE;
                  default: state_in = S_FIN;
               endcase
            end else if (stat.op == pts_pkg::OP_EXIT) begin
               cmd.exit_idle = 1'b1;
            end
         end
         S_TAKE: begin
            cmd.disp_take = 1'b1;
            state_in      = S_PARK;
         end
         S_PARK: begin
            cmd.disp_park = 1'b1;
            state_in      = S_FIN;
         end
         S_FIN: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         park_ff  <= pts_pkg::ST_READY;
      end else begin
         state_ff <= state_in;
         park_ff  <= park_in;
      end
   end

endmodule
`default_nettype wire

/* hdl/pts_dpath.sv */
// Scheduler datapath: task table, free FIFO, tick counter, scan unit, result register.
// Depends on pts_pkg; driven by pts_ctrl commands.
`default_nettype none
module pts_dpath #(
   parameter int MAX_TASKS = pts_pkg::MAX_TASKS_DEF
) (
   input  wire                clock,
   input  wire                reset,
   input  pts_pkg::cmd_type   cmd,
   output pts_pkg::stat_type  stat,
   input  wire [2:0]          in_opcode,
   input  wire [31:0]         in_delay_ticks,
   input  wire [7:0]          in_priority_req,
   input  wire [3:0]          in_owner_id,
   input  wire [7:0]          slice_cfg,
   input  wire                out_ready,
   output logic               out_valid,
   output logic [3:0]         out_running_id,
   output logic               out_running_valid,
   output logic               out_switched,
   output logic [3:0]         out_created_id,
   output logic               out_create_ok,
   output logic [4:0]         out_woken_count
);

   localparam int IDW = $clog2(MAX_TASKS);
   localparam int CW  = IDW + 1;
   localparam int PW  = IDW + 2;

   pts_pkg::status_type status_ff [MAX_TASKS];
   logic [7:0]          prio_ff   [MAX_TASKS];
   logic [7:0]          base_ff   [MAX_TASKS];
   logic [63:0]         alarm_ff  [MAX_TASKS];
   logic [7:0]          slice_ff  [MAX_TASKS];
   logic [IDW-1:0]      stamp_ff  [MAX_TASKS];
   logic [IDW-1:0]      fifo_ff   [MAX_TASKS];
   logic [IDW-1:0]      head_ff;
   logic [CW-1:0]       cnt_ff;
   logic [63:0]         tick_ff;
   logic [IDW-1:0]      cur_ff;
   logic                run_ff;
   pts_pkg::op_type     op_ff;
   logic [31:0]         delay_ff;
   logic [7:0]          preq_ff;
   logic [3:0]          owner_ff;
   logic [IDW-1:0]      idx_ff;
   logic                found_ff;
   logic [IDW-1:0]      best_ff;
   logic [7:0]          bp_ff;
   logic [IDW-1:0]      bs_ff;
   logic                sw_ff, cok_ff;
   logic [IDW-1:0]      cid_ff;
   logic [CW-1:0]       woken_ff;
   logic                ov_ff;

   logic           cand, better, owner_ok;
   logic [IDW-1:0] owner_idx, push_idx, head_in;
   logic [PW-1:0]  push_sum;

   always_comb begin
      cand = cmd.scan_expired
           ? (status_ff[idx_ff] == pts_pkg::ST_BLOCK &&
              !($signed(tick_ff) < $signed(alarm_ff[idx_ff])))
           : (status_ff[idx_ff] == pts_pkg::ST_READY);
      better = !found_ff || (prio_ff[idx_ff] < bp_ff) ||
               (prio_ff[idx_ff] == bp_ff && stamp_ff[idx_ff] > bs_ff);
      owner_idx = IDW'(owner_ff);
      owner_ok  = run_ff && (32'(owner_ff) < 32'(MAX_TASKS)) &&
                  status_ff[owner_idx] != pts_pkg::ST_FREE &&
                  prio_ff[owner_idx] > prio_ff[cur_ff];
      push_sum = PW'(head_ff) + PW'(cnt_ff);
      if (push_sum >= PW'(MAX_TASKS)) push_sum = push_sum - PW'(MAX_TASKS);
      push_idx = push_sum[IDW-1:0];
      head_in  = (32'(head_ff) == MAX_TASKS - 1) ? '0 : head_ff + 1'b1;
   end

   always_comb begin
      stat.op             = op_ff;
      stat.run            = run_ff;
      stat.delay_zero     = (delay_ff == 32'd0);
      stat.found          = found_ff;
      stat.scan_last      = (32'(idx_ff) == MAX_TASKS - 1);
      stat.prio_lt        = bp_ff < prio_ff[cur_ff];
      stat.prio_eq        = bp_ff == prio_ff[cur_ff];
      stat.slice_zero     = slice_ff[cur_ff] == 8'd0;
      stat.free_avail     = cnt_ff != '0;
      stat.create_preempt = prio_ff[cur_ff] > preq_ff;
      stat.out_free       = !ov_ff || out_ready;
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff    <= pts_pkg::op_type'(in_opcode);
         delay_ff <= in_delay_ticks;
         preq_ff  <= in_priority_req;
         owner_ff <= in_owner_id;
         sw_ff    <= 1'b0;
         cok_ff   <= 1'b0;
         cid_ff   <= '0;
         woken_ff <= '0;
      end
      if (cmd.scan_start) begin
         idx_ff   <= '0;
         found_ff <= 1'b0;
      end
      if (cmd.scan_step) begin
         idx_ff <= idx_ff + 1'b1;
         if (cand && better) begin
            found_ff <= 1'b1;
            best_ff  <= idx_ff;
            bp_ff    <= prio_ff[idx_ff];
            bs_ff    <= stamp_ff[idx_ff];
         end
      end
      if (cmd.set_alarm) alarm_ff[cur_ff] <= tick_ff + 64'(delay_ff);
      if (cmd.slice_dec) slice_ff[cur_ff] <= slice_ff[cur_ff] - 8'd1;
      if (cmd.do_restore) prio_ff[cur_ff] <= base_ff[cur_ff];
      if (cmd.wake) begin
         for (int i = 0; i < MAX_TASKS; i++) begin
            if (IDW'(i) != best_ff && status_ff[i] == pts_pkg::ST_BLOCK &&
                stamp_ff[i] > stamp_ff[best_ff])
               stamp_ff[i] <= stamp_ff[i] - 1'b1;
            if (status_ff[i] == pts_pkg::ST_READY) stamp_ff[i] <= stamp_ff[i] + 1'b1;
         end
         stamp_ff[best_ff] <= '0;
         woken_ff <= woken_ff + 1'b1;
      end
      if (cmd.disp_take) begin
         for (int i = 0; i < MAX_TASKS; i++)
            if (IDW'(i) != best_ff && status_ff[i] == pts_pkg::ST_READY &&
                stamp_ff[i] > stamp_ff[best_ff])
               stamp_ff[i] <= stamp_ff[i] - 1'b1;
      end
      if (cmd.disp_park) begin
         slice_ff[best_ff] <= slice_cfg;
         cur_ff            <= best_ff;
         sw_ff             <= 1'b1;
         if (run_ff && cmd.park == pts_pkg::ST_FREE) begin
            fifo_ff[push_idx] <= cur_ff;
         end else if (run_ff) begin
            for (int i = 0; i < MAX_TASKS; i++)
               if (IDW'(i) != cur_ff && status_ff[i] == cmd.park)
                  stamp_ff[i] <= stamp_ff[i] + 1'b1;
            stamp_ff[cur_ff] <= '0;
         end
      end
      if (cmd.exit_idle) fifo_ff[push_idx] <= cur_ff;
      if (cmd.do_create) begin
         prio_ff[fifo_ff[head_ff]] <= preq_ff;
         base_ff[fifo_ff[head_ff]] <= preq_ff;
         for (int i = 0; i < MAX_TASKS; i++)
            if (status_ff[i] == pts_pkg::ST_READY) stamp_ff[i] <= stamp_ff[i] + 1'b1;
         stamp_ff[fifo_ff[head_ff]] <= '0;
         cok_ff <= 1'b1;
         cid_ff <= fifo_ff[head_ff];
      end
      if (cmd.do_raise && owner_ok) begin
         prio_ff[owner_idx] <= prio_ff[cur_ff];
         if (status_ff[owner_idx] == pts_pkg::ST_READY ||
             status_ff[owner_idx] == pts_pkg::ST_BLOCK) begin
            for (int i = 0; i < MAX_TASKS; i++)
               if (IDW'(i) != owner_idx && status_ff[i] == status_ff[owner_idx])
                  stamp_ff[i] <= ((stamp_ff[i] > stamp_ff[owner_idx])
                                  ? stamp_ff[i] - 1'b1 : stamp_ff[i]) + 1'b1;
            stamp_ff[owner_idx] <= '0;
         end
      end
      if (cmd.load_out) begin
         out_running_id    <= run_ff ? 4'(cur_ff) : 4'd0;
         out_running_valid <= run_ff;
         out_switched      <= sw_ff;
         out_created_id    <= 4'(cid_ff);
         out_create_ok     <= cok_ff;
         out_woken_count   <= 5'(woken_ff);
      end

      if (reset) begin
         for (int i = 0; i < MAX_TASKS; i++) begin
            status_ff[i] <= pts_pkg::ST_FREE;
            fifo_ff[i]   <= IDW'(i);
         end
         head_ff <= '0;
         cnt_ff  <= CW'(MAX_TASKS);
         tick_ff <= '0;
         run_ff  <= 1'b0;
         ov_ff   <= 1'b0;
      end else begin
         if (cmd.tick_inc) tick_ff <= tick_ff + 64'd1;
         if (cmd.wake) status_ff[best_ff] <= pts_pkg::ST_READY;
         if (cmd.disp_park) begin
            if (run_ff) status_ff[cur_ff] <= cmd.park;
            status_ff[best_ff] <= pts_pkg::ST_RUN;
            run_ff             <= 1'b1;
            if (run_ff && cmd.park == pts_pkg::ST_FREE) cnt_ff <= cnt_ff + 1'b1;
         end
         if (cmd.exit_idle) begin
            status_ff[cur_ff] <= pts_pkg::ST_FREE;
            cnt_ff            <= cnt_ff + 1'b1;
            run_ff            <= 1'b0;
         end
         if (cmd.do_create) begin
            status_ff[fifo_ff[head_ff]] <= pts_pkg::ST_READY;
            head_ff <= head_in;
            cnt_ff  <= cnt_ff - 1'b1;
         end
         if (cmd.load_out) ov_ff <= 1'b1;
         else if (out_ready) ov_ff <= 1'b0;
      end
   end

   assign out_valid = ov_ff;

endmodule
`default_nettype wire

/* hdl/pts_csr.sv */
// APB-style register block holding the time slice setting.
// Depends on pts_pkg.
`default_nettype none
module pts_csr (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [2:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output logic [7:0]  slice_ticks
);

   logic [7:0] slice_ff;
   logic       hit;

   assign hit         = (csr_paddr == pts_pkg::CSR_SLICE_TICKS);
   assign csr_pready  = 1'b1;
   assign csr_prdata  = hit ? 32'(slice_ff) : 32'd0;
   assign slice_ticks = slice_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slice_ff <= pts_pkg::SLICE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && hit) begin
         slice_ff <= csr_pwdata[7:0];
      end
   end

endmodule
`default_nettype wire

/* hdl/pts_checker.sv */
// Port-level checks for the priority task scheduler, bound to the top level.
// Depends on priority_task_scheduler_unit.
`default_nettype none
module pts_checker (
   input wire       clock,
   input wire       reset,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire       running_valid,
   input wire       switched,
   input wire [3:0] created_id,
   input wire       create_ok
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("response beat dropped");

   a_switch_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && switched |-> running_valid) else $error("switch with nothing running");

   a_create_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !create_ok |-> created_id == 4'd0) else $error("stray created id");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("response after reset");

endmodule

bind priority_task_scheduler_unit pts_checker u_pts_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp_bus.valid), .rsp_ready(rsp_bus.ready),
   .running_valid(rsp_bus.running_valid), .switched(rsp_bus.switched),
   .created_id(rsp_bus.created_id), .create_ok(rsp_bus.create_ok)
);
`default_nettype wire
